/* rtl/sffh_pkg.sv */
// Package for the scalar field FNV-1a hasher: constants, types and the tag prefix hash.
`default_nettype none

package sffh_pkg;

  localparam logic [63:0] HASH_OFFSET_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] HASH_PRIME        = 64'h0000_0100_0000_01b3;
  localparam int unsigned PRIME_SHIFT       = 40;
  localparam logic [8:0]  PRIME_LOW         = 9'h1b3;

  localparam int unsigned TAG_LEN = 24;
  localparam logic [7:0] TAG_BYTES [TAG_LEN] = '{
    8'h63, 8'h75, 8'h62, 8'h65, 8'h79, 8'h2e, 8'h73, 8'h63,
    8'h61, 8'h6c, 8'h61, 8'h72, 8'h2d, 8'h66, 8'h69, 8'h65,
    8'h6c, 8'h64, 8'h2d, 8'h32, 8'h64, 8'h2e, 8'h76, 8'h31
  };

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT = 3'd5;

  localparam logic [1:0] KIND_VALUE        = 2'd0;
  localparam logic [1:0] KIND_VALUE_FINISH = 2'd1;
  localparam logic [1:0] KIND_FINISH       = 2'd2;
  localparam logic [1:0] KIND_NONE         = 2'd3;

  // header: five 32-bit words, then value_count as 64 bits
  localparam int unsigned  CNT_W    = 5;
  localparam logic [CNT_W-1:0] HDR_LAST = 5'd27;
  localparam logic [1:0]   VAL_LAST = 2'd3;

  localparam logic [2:0] WORD_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] WORD_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] WORD_CELL_SIZE   = 3'd2;
  localparam logic [2:0] WORD_ORIGIN_X    = 3'd3;
  localparam logic [2:0] WORD_ORIGIN_Y    = 3'd4;
  localparam logic [2:0] WORD_COUNT_LO    = 3'd5;

  typedef struct packed {
    logic [31:0] grid_width;
    logic [31:0] grid_height;
    logic [31:0] cell_size_bits;
    logic [31:0] origin_x_bits;
    logic [31:0] origin_y_bits;
    logic [31:0] value_count;
  } sffh_cfg_t;

  typedef struct packed {
    logic             hdr;
    logic [CNT_W-1:0] cnt;
  } sffh_step_t;

  function automatic logic [63:0] mix_const(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'h0, b};
    return x * HASH_PRIME;
  endfunction

  // offset basis after the tag length (64-bit LE) and the tag bytes
  function automatic logic [63:0] tag_prefix_hash();
    logic [63:0] h;
    logic [63:0] len;
    h   = HASH_OFFSET_BASIS;
    len = 64'(TAG_LEN);
    for (int i = 0; i < 8; i++) begin
      h = mix_const(h, len[8*i +: 8]);
    end
    for (int i = 0; i < TAG_LEN; i++) begin
      h = mix_const(h, TAG_BYTES[i]);
    end
    return h;
  endfunction

  localparam logic [63:0] HASH_TAG_INIT = tag_prefix_hash();

endpackage

`default_nettype wire

/* rtl/sffh_mix.sv */
// Byte select and one FNV-1a XOR-multiply step on the running hash.
`default_nettype none

module sffh_mix (
  input  wire logic [63:0]          hash_in,
  input  wire sffh_pkg::sffh_cfg_t  cfg,
  input  wire logic [31:0]          value_bits,
  input  wire sffh_pkg::sffh_step_t step,
  output logic [63:0]               hash_out
);
  import sffh_pkg::*;

  logic [31:0] hdr_word;
  logic [31:0] word;
  logic [7:0]  byte_sel;
  logic [63:0] x;

  always_comb begin
    case (step.cnt[4:2])
      WORD_GRID_WIDTH:  hdr_word = cfg.grid_width;
      WORD_GRID_HEIGHT: hdr_word = cfg.grid_height;
      WORD_CELL_SIZE:   hdr_word = cfg.cell_size_bits;
      WORD_ORIGIN_X:    hdr_word = cfg.origin_x_bits;
      WORD_ORIGIN_Y:    hdr_word = cfg.origin_y_bits;
      WORD_COUNT_LO:    hdr_word = cfg.value_count;
      default:          hdr_word = 32'h0;
    endcase
    word     = step.hdr ? hdr_word : value_bits;
    byte_sel = word[8*step.cnt[1:0] +: 8];
    x        = hash_in ^ {56'h0, byte_sel};
    // prime = 2^40 + 0x1b3
    hash_out = (x << PRIME_SHIFT) + 64'(x * {55'h0, PRIME_LOW});
  end

endmodule

`default_nettype wire

/* rtl/scalar_field_fnv1a_hasher.sv */
// Top level of the scalar field FNV-1a content hasher.
//
//  channel  dir  handshake                tdata / payload
//  in_      in   in_tvalid/in_tready      value_bits, tuser kind
//  out_     out  out_tvalid/out_tready    field_hash
//  cfg_     in   cfg_valid/cfg_ready      cfg_index, cfg_data
//
// One byte is mixed per cycle through a single XOR-multiply unit.
// A value item is accepted and then its four bytes are mixed; the first item of a field
// first mixes the 28 header bytes (tag prefix is a constant loaded in one step).
// A finishing item loads the output register from the done state after any mixing,
// or waits there while an earlier hash is still not taken.
// rst_n is synchronous, active low; cfg_ready is always high.
`default_nettype none

module scalar_field_fnv1a_hasher (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [31:0]                       in_tdata,   // [31:0] value_bits
  input  wire logic [1:0]                        in_tuser,   // [1:0] kind
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [63:0]                            out_tdata,  // [63:0] field_hash
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sffh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                       cfg_data
);
  import sffh_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HEAD  = 4'b0010,
    ST_VALUE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]      hash_r, hash_nxt;
  logic             started_r, started_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [31:0]      val_r, val_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_data_r, out_data_nxt;
  sffh_cfg_t        cfg_r;
  sffh_step_t       step;
  logic [63:0]      mix_out;
  logic             in_acc;
  logic             out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;

  assign step.hdr = (state_r == ST_HEAD);
  assign step.cnt = cnt_r;

  sffh_mix u_mix (
    .hash_in    (hash_r),
    .cfg        (cfg_r),
    .value_bits (val_r),
    .step       (step),
    .hash_out   (mix_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH:  cfg_r.grid_width     <= cfg_data;
        REG_GRID_HEIGHT: cfg_r.grid_height    <= cfg_data;
        REG_CELL_SIZE:   cfg_r.cell_size_bits <= cfg_data;
        REG_ORIGIN_X:    cfg_r.origin_x_bits  <= cfg_data;
        REG_ORIGIN_Y:    cfg_r.origin_y_bits  <= cfg_data;
        REG_VALUE_COUNT: cfg_r.value_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hash_nxt      = hash_r;
    started_nxt   = started_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser != KIND_NONE) begin
          kind_nxt = in_tuser;
          val_nxt  = in_tdata;
          cnt_nxt  = '0;
          if (!started_r) begin
            hash_nxt  = HASH_TAG_INIT;
            state_nxt = ST_HEAD;
          end else if (in_tuser == KIND_FINISH) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_VALUE;
          end
        end
      end
      ST_HEAD: begin
        hash_nxt = mix_out;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == HDR_LAST) begin
          started_nxt = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = (kind_r == KIND_FINISH) ? ST_DONE : ST_VALUE;
        end
      end
      ST_VALUE: begin
        hash_nxt = mix_out;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r[1:0] == VAL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = (kind_r == KIND_VALUE) ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hash_r;
          started_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      hash_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hash_r      <= hash_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  a_hdr_opens_field: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HEAD && cnt_r == HDR_LAST) |=> started_r)
    else $error("header end did not open field");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && !started_r && state_r == ST_IDLE))
    else $error("finish did not deliver hash");

  a_none_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == KIND_NONE) |=> (state_r == ST_IDLE && $stable(hash_r)))
    else $error("ignored kind changed state");

  a_value_needs_field: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VALUE) |-> started_r)
    else $error("value mixed without open field");

endmodule

`default_nettype wire
